/* design/instruction_byte_encoder_unit_assert.svh */
// assertion macros shared by the encoder checkers
// depends on nothing; pulled in by `include
`ifndef INSTRUCTION_BYTE_ENCODER_UNIT_ASSERT_SVH
`define INSTRUCTION_BYTE_ENCODER_UNIT_ASSERT_SVH

// property checked on every clock edge outside reset
`define IBE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that also has to hold while reset is asserted
`define IBE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/ibe_pkg.sv */
// types, codes and decode helpers for the 65C02 instruction byte encoder
// no dependencies
package ibe_pkg;

    // status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_BAD_OP = 3'd1;
    localparam logic [2:0] ST_BAD_K1 = 3'd2;
    localparam logic [2:0] ST_BAD_K2 = 3'd3;
    localparam logic [2:0] ST_RANGE1 = 3'd4;
    localparam logic [2:0] ST_RANGE2 = 3'd5;
    localparam logic [2:0] ST_FAR    = 3'd6;

    // operand kinds
    localparam logic [4:0] K_NONE = 5'd0;
    localparam logic [4:0] K_A    = 5'd1;
    localparam logic [4:0] K_X    = 5'd2;
    localparam logic [4:0] K_Y    = 5'd3;
    localparam logic [4:0] K_S    = 5'd4;
    localparam logic [4:0] K_P    = 5'd5;
    localparam logic [4:0] K_IMM  = 5'd6;
    localparam logic [4:0] K_ABS  = 5'd7;
    localparam logic [4:0] K_ABSX = 5'd8;
    localparam logic [4:0] K_ABSY = 5'd9;
    localparam logic [4:0] K_ZP   = 5'd10;
    localparam logic [4:0] K_ZPX  = 5'd11;
    localparam logic [4:0] K_ZPY  = 5'd12;
    localparam logic [4:0] K_IZP  = 5'd13;
    localparam logic [4:0] K_IZPX = 5'd14;
    localparam logic [4:0] K_IZPY = 5'd15;
    localparam logic [4:0] K_NF   = 5'd16;
    localparam logic [4:0] K_VF   = 5'd17;
    localparam logic [4:0] K_CF   = 5'd18;
    localparam logic [4:0] K_ZF   = 5'd19;
    localparam logic [4:0] K_IF   = 5'd20;
    localparam logic [4:0] K_DF   = 5'd21;
    localparam logic [4:0] K_ALW  = 5'd22;

    // operations
    localparam logic [4:0] OP_MOV  = 5'd0;
    localparam logic [4:0] OP_PULL = 5'd1;
    localparam logic [4:0] OP_PUSH = 5'd2;
    localparam logic [4:0] OP_SET  = 5'd3;
    localparam logic [4:0] OP_CLR  = 5'd4;
    localparam logic [4:0] OP_ADDC = 5'd5;
    localparam logic [4:0] OP_SUBC = 5'd6;
    localparam logic [4:0] OP_AND  = 5'd7;
    localparam logic [4:0] OP_OR   = 5'd8;
    localparam logic [4:0] OP_XOR  = 5'd9;
    localparam logic [4:0] OP_INC  = 5'd10;
    localparam logic [4:0] OP_DEC  = 5'd11;
    localparam logic [4:0] OP_ROR  = 5'd12;
    localparam logic [4:0] OP_ROL  = 5'd13;
    localparam logic [4:0] OP_ASL  = 5'd14;
    localparam logic [4:0] OP_LSR  = 5'd15;
    localparam logic [4:0] OP_CMP  = 5'd16;
    localparam logic [4:0] OP_BIT  = 5'd17;
    localparam logic [4:0] OP_TRB  = 5'd18;
    localparam logic [4:0] OP_TSB  = 5'd19;
    localparam logic [4:0] OP_NOP  = 5'd20;
    localparam logic [4:0] OP_JMP  = 5'd21;
    localparam logic [4:0] OP_BR   = 5'd22;
    localparam logic [4:0] OP_CALL = 5'd23;
    localparam logic [4:0] OP_RET  = 5'd24;
    localparam logic [4:0] OP_RETI = 5'd25;
    localparam logic [4:0] OP_BRK  = 5'd26;
    localparam logic [4:0] OP_STOP = 5'd27;
    localparam logic [4:0] OP_WAIT = 5'd28;

    // instruction forms picked by the decode
    localparam logic [2:0] FORM_ERR    = 3'd0;
    localparam logic [2:0] FORM_ONE    = 3'd1;
    localparam logic [2:0] FORM_BYTE   = 3'd2;
    localparam logic [2:0] FORM_WORD   = 3'd3;
    localparam logic [2:0] FORM_BRANCH = 3'd4;
    localparam logic [2:0] FORM_BRK    = 3'd5;

    localparam logic [7:0] BRK_PAD = 8'hea;

    typedef struct packed {
        logic signed [31:0] instr_addr;
        logic [4:0]         op_code;
        logic [4:0]         first_kind;
        logic signed [31:0] first_value;
        logic [4:0]         second_kind;
        logic signed [31:0] second_value;
    } ibe_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [1:0] byte_count;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
    } ibe_out_t;

    // what the decode settled: form, opcode, which operand, error codes
    typedef struct packed {
        logic [2:0] form;
        logic [7:0] code;
        logic       use_v2;
        logic [2:0] rerr;
        logic [2:0] err;
    } ibe_plan_t;

    function automatic ibe_plan_t plan_err(logic [2:0] st);
        ibe_plan_t p;
        p      = '0;
        p.form = FORM_ERR;
        p.err  = st;
        return p;
    endfunction

    function automatic ibe_plan_t plan_one(logic [7:0] code);
        ibe_plan_t p;
        p      = '0;
        p.form = FORM_ONE;
        p.code = code;
        return p;
    endfunction

    function automatic ibe_plan_t plan_byte(logic [7:0] code, logic use_v2, logic [2:0] rerr);
        ibe_plan_t p;
        p        = '0;
        p.form   = FORM_BYTE;
        p.code   = code;
        p.use_v2 = use_v2;
        p.rerr   = rerr;
        return p;
    endfunction

    function automatic ibe_plan_t plan_word(logic [7:0] code, logic use_v2, logic [2:0] rerr);
        ibe_plan_t p;
        p        = '0;
        p.form   = FORM_WORD;
        p.code   = code;
        p.use_v2 = use_v2;
        p.rerr   = rerr;
        return p;
    endfunction

    function automatic ibe_plan_t plan_branch(logic [7:0] code);
        ibe_plan_t p;
        p        = '0;
        p.form   = FORM_BRANCH;
        p.code   = code;
        p.use_v2 = 1'b1;
        p.rerr   = ST_RANGE2;
        return p;
    endfunction

    // accumulator group, also loads and stores of A
    function automatic ibe_plan_t acc_plan(logic [4:0] op, logic [4:0] k1, logic [4:0] k2);
        logic [7:0] base;
        logic [4:0] mode;
        logic       use_v2;
        logic [2:0] rerr;
        logic [2:0] ek;
        logic       bad_op;
        logic       bad_k1;
        ibe_plan_t  p;
        base   = 8'h00;
        mode   = k2;
        use_v2 = 1'b1;
        rerr   = ST_RANGE2;
        ek     = ST_BAD_K2;
        bad_op = 1'b0;
        bad_k1 = 1'b0;
        if (k1 != K_A) begin
            // store of A: addressing comes from the first operand, never immediate
            bad_k1 = (op != OP_MOV) || (k2 != K_A) || (k1 == K_IMM);
            base   = 8'h80;
            mode   = k1;
            use_v2 = 1'b0;
            rerr   = ST_RANGE1;
            ek     = ST_BAD_K1;
        end else begin
            case (op)
                OP_ADDC: base = 8'h60;
                OP_SUBC: base = 8'he0;
                OP_AND:  base = 8'h20;
                OP_OR:   base = 8'h00;
                OP_XOR:  base = 8'h40;
                OP_CMP:  base = 8'hc0;
                OP_MOV:  base = 8'ha0;
                default: bad_op = 1'b1;
            endcase
        end
        case (mode)
            K_IMM:   p = plan_byte(base + 8'h09, use_v2, rerr);
            K_ABS:   p = plan_word(base + 8'h0d, use_v2, rerr);
            K_ABSX:  p = plan_word(base + 8'h1d, use_v2, rerr);
            K_ABSY:  p = plan_word(base + 8'h19, use_v2, rerr);
            K_ZP:    p = plan_byte(base + 8'h05, use_v2, rerr);
            K_ZPX:   p = plan_byte(base + 8'h15, use_v2, rerr);
            K_IZP:   p = plan_byte(base + 8'h12, use_v2, rerr);
            K_IZPX:  p = plan_byte(base + 8'h01, use_v2, rerr);
            K_IZPY:  p = plan_byte(base + 8'h11, use_v2, rerr);
            default: p = plan_err(ek);
        endcase
        if (bad_op) begin
            p = plan_err(ST_BAD_OP);
        end
        if (bad_k1) begin
            p = plan_err(ST_BAD_K1);
        end
        return p;
    endfunction

    // increments, decrements, shifts and rotates
    function automatic ibe_plan_t shift_plan(logic [4:0] op, logic [4:0] k1, logic [4:0] k2);
        logic [7:0] base;
        logic       bad_op;
        ibe_plan_t  p;
        base   = 8'h00;
        bad_op = 1'b0;
        case (op)
            OP_INC:  base = 8'he0;
            OP_DEC:  base = 8'hc0;
            OP_ROR:  base = 8'h60;
            OP_ROL:  base = 8'h20;
            OP_ASL:  base = 8'h00;
            OP_LSR:  base = 8'h40;
            default: bad_op = 1'b1;
        endcase
        case (k1)
            K_A:     p = plan_one(base + 8'h0a);
            K_ABS:   p = plan_word(base + 8'h0e, 1'b0, ST_RANGE1);
            K_ABSX:  p = plan_word(base + 8'h1e, 1'b0, ST_RANGE1);
            K_ZP:    p = plan_byte(base + 8'h06, 1'b0, ST_RANGE1);
            K_ZPX:   p = plan_byte(base + 8'h16, 1'b0, ST_RANGE1);
            default: p = plan_err(ST_BAD_K1);
        endcase
        // register forms of inc and dec have their own opcodes
        if (op == OP_INC) begin
            if (k1 == K_A) p = plan_one(8'h1a);
            if (k1 == K_X) p = plan_one(8'he8);
            if (k1 == K_Y) p = plan_one(8'hc8);
        end
        if (op == OP_DEC) begin
            if (k1 == K_A) p = plan_one(8'h3a);
            if (k1 == K_X) p = plan_one(8'hca);
            if (k1 == K_Y) p = plan_one(8'h88);
        end
        if (bad_op) begin
            p = plan_err(ST_BAD_OP);
        end
        if (k2 != K_NONE) begin
            p = plan_err(ST_BAD_K2);
        end
        return p;
    endfunction

    // loads, stores and transfers
    function automatic ibe_plan_t move_plan(logic [4:0] k1, logic [4:0] k2, logic v2_zero);
        ibe_plan_t p;
        if (k1 == K_A) begin
            if (k2 == K_X)      p = plan_one(8'h8a);
            else if (k2 == K_Y) p = plan_one(8'h98);
            else                p = acc_plan(OP_MOV, k1, k2);
        end else if (k2 == K_A) begin
            if (k1 == K_X)      p = plan_one(8'haa);
            else if (k1 == K_Y) p = plan_one(8'ha8);
            else                p = acc_plan(OP_MOV, k1, k2);
        end else if (k1 == K_X) begin
            case (k2)
                K_S:     p = plan_one(8'hba);
                K_IMM:   p = plan_byte(8'ha2, 1'b1, ST_RANGE2);
                K_ABS:   p = plan_word(8'hae, 1'b1, ST_RANGE2);
                K_ABSY:  p = plan_word(8'hbe, 1'b1, ST_RANGE2);
                K_ZP:    p = plan_byte(8'ha6, 1'b1, ST_RANGE2);
                K_ZPY:   p = plan_byte(8'hb6, 1'b1, ST_RANGE2);
                default: p = plan_err(ST_BAD_K2);
            endcase
        end else if (k1 == K_Y) begin
            case (k2)
                K_IMM:   p = plan_byte(8'ha0, 1'b1, ST_RANGE2);
                K_ABS:   p = plan_word(8'hac, 1'b1, ST_RANGE2);
                K_ABSX:  p = plan_word(8'hbc, 1'b1, ST_RANGE2);
                K_ZP:    p = plan_byte(8'ha4, 1'b1, ST_RANGE2);
                K_ZPX:   p = plan_byte(8'hb4, 1'b1, ST_RANGE2);
                default: p = plan_err(ST_BAD_K2);
            endcase
        end else if (k2 == K_X) begin
            case (k1)
                K_S:     p = plan_one(8'h9a);
                K_ABS:   p = plan_word(8'h8e, 1'b0, ST_RANGE1);
                K_ZP:    p = plan_byte(8'h86, 1'b0, ST_RANGE1);
                K_ZPY:   p = plan_byte(8'h96, 1'b0, ST_RANGE1);
                default: p = plan_err(ST_BAD_K2);
            endcase
        end else if (k2 == K_Y) begin
            case (k1)
                K_ABS:   p = plan_word(8'h8c, 1'b0, ST_RANGE1);
                K_ZP:    p = plan_byte(8'h84, 1'b0, ST_RANGE1);
                K_ZPX:   p = plan_byte(8'h94, 1'b0, ST_RANGE1);
                default: p = plan_err(ST_BAD_K2);
            endcase
        end else if (k2 == K_IMM) begin
            // store zero: only an immediate of zero is encodable
            if (!v2_zero) begin
                p = plan_err(ST_RANGE2);
            end else begin
                case (k1)
                    K_ABS:   p = plan_word(8'h9c, 1'b0, ST_RANGE1);
                    K_ABSX:  p = plan_word(8'h9e, 1'b0, ST_RANGE1);
                    K_ZP:    p = plan_byte(8'h64, 1'b0, ST_RANGE1);
                    K_ZPX:   p = plan_byte(8'h74, 1'b0, ST_RANGE1);
                    default: p = plan_err(ST_BAD_K2);
                endcase
            end
        end else begin
            p = plan_err(ST_BAD_K1);
        end
        return p;
    endfunction

endpackage

/* design/ibe_encode.sv */
// combinational encoder: one symbolic instruction in, bytes and status out
// depends on ibe_pkg
module ibe_encode import ibe_pkg::*; (
    input  ibe_in_t  req,
    output ibe_out_t res
);

    ibe_plan_t          plan;
    logic               set_cond;
    logic signed [31:0] v_sel;
    logic               byte_ok;
    logic               word_ok;
    logic               addr_ok;
    logic [17:0]        br_off;
    logic               near;

    assign set_cond = (req.first_value != '0);

    always_comb begin
        case (req.op_code)
            OP_MOV: begin
                plan = move_plan(req.first_kind, req.second_kind, req.second_value == '0);
            end
            OP_PULL, OP_PUSH: begin
                case (req.first_kind)
                    K_A:     plan = plan_one((req.op_code == OP_PULL) ? 8'h68 : 8'h48);
                    K_X:     plan = plan_one((req.op_code == OP_PULL) ? 8'hfa : 8'hda);
                    K_Y:     plan = plan_one((req.op_code == OP_PULL) ? 8'h7a : 8'h5a);
                    K_P:     plan = plan_one((req.op_code == OP_PULL) ? 8'h28 : 8'h08);
                    default: plan = plan_err(ST_BAD_K1);
                endcase
                if (req.second_kind != K_NONE) plan = plan_err(ST_BAD_K2);
            end
            OP_SET: begin
                case (req.first_kind)
                    K_CF:    plan = plan_one(8'h38);
                    K_IF:    plan = plan_one(8'h78);
                    K_DF:    plan = plan_one(8'hf8);
                    default: plan = plan_err(ST_BAD_K1);
                endcase
                if (req.second_kind != K_NONE) plan = plan_err(ST_BAD_K2);
            end
            OP_CLR: begin
                case (req.first_kind)
                    K_CF:    plan = plan_one(8'h18);
                    K_IF:    plan = plan_one(8'h58);
                    K_VF:    plan = plan_one(8'hb8);
                    K_DF:    plan = plan_one(8'hd8);
                    default: plan = plan_err(ST_BAD_K1);
                endcase
                if (req.second_kind != K_NONE) plan = plan_err(ST_BAD_K2);
            end
            OP_ADDC, OP_SUBC, OP_AND, OP_OR, OP_XOR: begin
                plan = acc_plan(req.op_code, req.first_kind, req.second_kind);
            end
            OP_INC, OP_DEC, OP_ROR, OP_ROL, OP_ASL, OP_LSR: begin
                plan = shift_plan(req.op_code, req.first_kind, req.second_kind);
            end
            OP_CMP: begin
                if (req.first_kind == K_X || req.first_kind == K_Y) begin
                    // cpx / cpy share a layout, 0x20 apart
                    case (req.second_kind)
                        K_IMM: plan = plan_byte((req.first_kind == K_X) ? 8'he0 : 8'hc0,
                                                1'b1, ST_RANGE2);
                        K_ABS: plan = plan_word((req.first_kind == K_X) ? 8'hec : 8'hcc,
                                                1'b1, ST_RANGE2);
                        K_ZP:  plan = plan_byte((req.first_kind == K_X) ? 8'he4 : 8'hc4,
                                                1'b1, ST_RANGE2);
                        default: plan = plan_err(ST_BAD_K2);
                    endcase
                end else begin
                    plan = acc_plan(req.op_code, req.first_kind, req.second_kind);
                end
            end
            OP_BIT: begin
                case (req.first_kind)
                    K_ABS:   plan = plan_word(8'h2c, 1'b0, ST_RANGE1);
                    K_ABSX:  plan = plan_word(8'h3c, 1'b0, ST_RANGE1);
                    K_IMM:   plan = plan_byte(8'h89, 1'b0, ST_RANGE1);
                    K_ZP:    plan = plan_byte(8'h24, 1'b0, ST_RANGE1);
                    K_ZPX:   plan = plan_byte(8'h34, 1'b0, ST_RANGE1);
                    default: plan = plan_err(ST_BAD_K1);
                endcase
                if (req.second_kind != K_NONE) plan = plan_err(ST_BAD_K2);
            end
            OP_TRB, OP_TSB: begin
                case (req.first_kind)
                    K_ABS:   plan = plan_word((req.op_code == OP_TRB) ? 8'h1c : 8'h0c,
                                              1'b0, ST_RANGE1);
                    K_ZP:    plan = plan_byte((req.op_code == OP_TRB) ? 8'h14 : 8'h04,
                                              1'b0, ST_RANGE1);
                    default: plan = plan_err(ST_BAD_K1);
                endcase
                if (req.second_kind != K_NONE) plan = plan_err(ST_BAD_K2);
            end
            OP_NOP: begin
                if (req.first_kind != K_NONE)       plan = plan_err(ST_BAD_K1);
                else if (req.second_kind != K_NONE) plan = plan_err(ST_BAD_K2);
                else                                plan = plan_one(8'hea);
            end
            OP_JMP: begin
                case (req.first_kind)
                    K_IMM:   plan = plan_word(8'h4c, 1'b0, ST_RANGE1);
                    K_ABS:   plan = plan_word(8'h6c, 1'b0, ST_RANGE1);
                    K_ABSX:  plan = plan_word(8'h7c, 1'b0, ST_RANGE1);
                    default: plan = plan_err(ST_BAD_K1);
                endcase
                if (req.second_kind != K_NONE) plan = plan_err(ST_BAD_K2);
            end
            OP_BR: begin
                case (req.first_kind)
                    K_NF:    plan = plan_branch(set_cond ? 8'h30 : 8'h10);
                    K_VF:    plan = plan_branch(set_cond ? 8'h70 : 8'h50);
                    K_CF:    plan = plan_branch(set_cond ? 8'hb0 : 8'h90);
                    K_ZF:    plan = plan_branch(set_cond ? 8'hf0 : 8'hd0);
                    K_ALW:   plan = plan_branch(8'h80);
                    default: plan = plan_err(ST_BAD_K1);
                endcase
                if (req.second_kind != K_IMM) plan = plan_err(ST_BAD_K2);
            end
            OP_CALL: begin
                if (req.first_kind != K_IMM)        plan = plan_err(ST_BAD_K1);
                else if (req.second_kind != K_NONE) plan = plan_err(ST_BAD_K2);
                else                                plan = plan_word(8'h20, 1'b0, ST_RANGE1);
            end
            OP_RET, OP_RETI, OP_BRK, OP_STOP, OP_WAIT: begin
                case (req.op_code)
                    OP_RET:  plan = plan_one(8'h60);
                    OP_RETI: plan = plan_one(8'h40);
                    OP_STOP: plan = plan_one(8'hdb);
                    OP_WAIT: plan = plan_one(8'hcb);
                    default: begin
                        plan      = plan_one(8'h00);
                        plan.form = FORM_BRK;
                    end
                endcase
                if (req.first_kind != K_NONE || req.second_kind != K_NONE) begin
                    plan = plan_err(ST_BAD_K1);
                end
            end
            default: plan = plan_err(ST_BAD_OP);
        endcase
    end

    // operand range checks and branch distance
    assign v_sel   = plan.use_v2 ? req.second_value : req.first_value;
    assign byte_ok = (v_sel[31:8] == '0);
    assign word_ok = (v_sel[31:16] == '0);
    assign addr_ok = (req.instr_addr[31:16] == '0) && (req.second_value[31:16] == '0);
    assign br_off  = {2'b00, req.second_value[15:0]} - {2'b00, req.instr_addr[15:0]} - 18'd2;
    assign near    = (br_off[17:7] == '0) || (br_off[17:7] == '1);

    always_comb begin
        res = '0;
        case (plan.form)
            FORM_ERR: begin
                res.status = plan.err;
            end
            FORM_ONE: begin
                res.byte_count = 2'd1;
                res.first_byte = plan.code;
            end
            FORM_BYTE: begin
                if (byte_ok) begin
                    res.byte_count  = 2'd2;
                    res.first_byte  = plan.code;
                    res.second_byte = v_sel[7:0];
                end else begin
                    res.status = plan.rerr;
                end
            end
            FORM_WORD: begin
                if (word_ok) begin
                    res.byte_count  = 2'd3;
                    res.first_byte  = plan.code;
                    res.second_byte = v_sel[7:0];
                    res.third_byte  = v_sel[15:8];
                end else begin
                    res.status = plan.rerr;
                end
            end
            FORM_BRANCH: begin
                if (!addr_ok) begin
                    res.status = ST_RANGE2;
                end else if (!near) begin
                    res.status = ST_FAR;
                end else begin
                    res.byte_count  = 2'd2;
                    res.first_byte  = plan.code;
                    res.second_byte = br_off[7:0];
                end
            end
            FORM_BRK: begin
                res.byte_count  = 2'd2;
                res.first_byte  = plan.code;
                res.second_byte = BRK_PAD;
            end
            default: res = '0;
        endcase
    end

endmodule

/* design/instruction_byte_encoder_unit.sv */
// an accepted request is held in the request register, encoded, then held in the result register that drives m_valid
// throughput: one request per cycle while results are taken; both the request and result registers
// advance together whenever the result register is empty or being taken, and an empty request register also takes one
// reset: synchronous, active low on aresetn; clears both valid flags only
// depends on ibe_pkg and ibe_encode
module instruction_byte_encoder_unit import ibe_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ibe_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ibe_out_t m_data
);

    logic     in_valid_reg;
    ibe_in_t  in_data_reg;
    logic     out_valid_reg;
    ibe_out_t out_data_reg;
    logic     out_ready;
    ibe_out_t enc_res;

    assign out_ready = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    ibe_encode u_encode (
        .req (in_data_reg),
        .res (enc_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_reg && out_ready) begin
            out_data_reg <= enc_res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

/* design/ibe_check.sv */
// port-level checker for the instruction byte encoder, bound to the top level
// depends on ibe_pkg and instruction_byte_encoder_unit_assert.svh
`include "instruction_byte_encoder_unit_assert.svh"

module ibe_check import ibe_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input ibe_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input ibe_out_t m_data
);

    // a stalled result holds
    `IBE_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result changed while stalled")

    // an error carries no bytes
    `IBE_ASSERT(a_err_zero, aclk, aresetn, m_valid && m_data.status != ST_OK |-> m_data.byte_count == 2'd0 && m_data.first_byte == 8'h00 && m_data.second_byte == 8'h00 && m_data.third_byte == 8'h00, "error result with bytes")

    // a good result carries at least the opcode
    `IBE_ASSERT(a_ok_count, aclk, aresetn, m_valid && m_data.status == ST_OK |-> m_data.byte_count != 2'd0, "ok result with no bytes")

    // nothing comes out right after reset
    `IBE_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind instruction_byte_encoder_unit ibe_check u_check (.*);

/* tb/ibe_encode_tb_pkg.sv */
// expected-result model of the 65C02 instruction byte encoder and its scoreboard
// depends on ibe_pkg for the request and result structs and the code names
package ibe_encode_tb_pkg;
    import ibe_pkg::*;

    function automatic ibe_out_t enc_err(logic [2:0] st);
        ibe_out_t o;
        o = '0;
        o.status = st;
        return o;
    endfunction

    function automatic ibe_out_t enc_one(logic [7:0] code);
        ibe_out_t o;
        o = '0;
        o.byte_count = 2'd1;
        o.first_byte = code;
        return o;
    endfunction

    function automatic ibe_out_t enc_byte(logic [7:0] code, longint v, logic [2:0] err);
        ibe_out_t o;
        if (v < 0 || v > 255) return enc_err(err);
        o = '0;
        o.byte_count  = 2'd2;
        o.first_byte  = code;
        o.second_byte = v[7:0];
        return o;
    endfunction

    // word operands go out low byte first
    function automatic ibe_out_t enc_word(logic [7:0] code, longint v, logic [2:0] err);
        ibe_out_t o;
        if (v < 0 || v > 65535) return enc_err(err);
        o = '0;
        o.byte_count  = 2'd3;
        o.first_byte  = code;
        o.second_byte = v[7:0];
        o.third_byte  = v[15:8];
        return o;
    endfunction

    function automatic ibe_out_t enc_branch(logic [7:0] code, longint addr, longint target);
        longint   offset;
        ibe_out_t o;
        if (addr < 0 || addr > 65535 || target < 0 || target > 65535) return enc_err(ST_RANGE2);
        offset = target - addr - 2;
        if (offset < -128 || offset > 127) return enc_err(ST_FAR);
        o = '0;
        o.byte_count  = 2'd2;
        o.first_byte  = code;
        o.second_byte = offset[7:0];
        return o;
    endfunction

    // accumulator ops, plus loads and stores of A
    function automatic ibe_out_t enc_acc(logic [4:0] op, logic [4:0] k1, longint v1,
                                         logic [4:0] k2, longint v2);
        logic [7:0] base;
        logic [4:0] mode;
        longint     val;
        logic [2:0] er;
        logic [2:0] ek;
        base = 8'h00;
        if (k1 != K_A) begin
            // store of A, addressing taken from the first operand
            if (op != OP_MOV || k2 != K_A || k1 == K_IMM) return enc_err(ST_BAD_K1);
            base = 8'h80;
            mode = k1;
            val  = v1;
            er   = ST_RANGE1;
            ek   = ST_BAD_K1;
        end else begin
            mode = k2;
            val  = v2;
            er   = ST_RANGE2;
            ek   = ST_BAD_K2;
            case (op)
                OP_ADDC: base = 8'h60;
                OP_SUBC: base = 8'he0;
                OP_AND:  base = 8'h20;
                OP_OR:   base = 8'h00;
                OP_XOR:  base = 8'h40;
                OP_CMP:  base = 8'hc0;
                OP_MOV:  base = 8'ha0;
                default: return enc_err(ST_BAD_OP);
            endcase
        end
        case (mode)
            K_IMM:   return enc_byte(base + 8'h09, val, er);
            K_ABS:   return enc_word(base + 8'h0d, val, er);
            K_ABSX:  return enc_word(base + 8'h1d, val, er);
            K_ABSY:  return enc_word(base + 8'h19, val, er);
            K_ZP:    return enc_byte(base + 8'h05, val, er);
            K_ZPX:   return enc_byte(base + 8'h15, val, er);
            K_IZP:   return enc_byte(base + 8'h12, val, er);
            K_IZPX:  return enc_byte(base + 8'h01, val, er);
            K_IZPY:  return enc_byte(base + 8'h11, val, er);
            default: return enc_err(ek);
        endcase
    endfunction

    function automatic ibe_out_t predict_encoding(ibe_in_t req);
        longint     addr;
        longint     v1;
        longint     v2;
        logic [4:0] op;
        logic [4:0] k1;
        logic [4:0] k2;
        logic [7:0] b;
        logic       cond_set;
        addr     = $signed(req.instr_addr);
        v1       = $signed(req.first_value);
        v2       = $signed(req.second_value);
        op       = req.op_code;
        k1       = req.first_kind;
        k2       = req.second_kind;
        cond_set = (v1 != 0);
        b        = 8'h00;
        case (op)
            OP_MOV: begin
                if (k1 == K_A) begin
                    if (k2 == K_X) return enc_one(8'h8a);
                    if (k2 == K_Y) return enc_one(8'h98);
                    return enc_acc(op, k1, v1, k2, v2);
                end
                if (k2 == K_A) begin
                    if (k1 == K_X) return enc_one(8'haa);
                    if (k1 == K_Y) return enc_one(8'ha8);
                    return enc_acc(op, k1, v1, k2, v2);
                end
                if (k1 == K_X) begin
                    case (k2)
                        K_S:     return enc_one(8'hba);
                        K_IMM:   return enc_byte(8'ha2, v2, ST_RANGE2);
                        K_ABS:   return enc_word(8'hae, v2, ST_RANGE2);
                        K_ABSY:  return enc_word(8'hbe, v2, ST_RANGE2);
                        K_ZP:    return enc_byte(8'ha6, v2, ST_RANGE2);
                        K_ZPY:   return enc_byte(8'hb6, v2, ST_RANGE2);
                        default: return enc_err(ST_BAD_K2);
                    endcase
                end
                if (k1 == K_Y) begin
                    case (k2)
                        K_IMM:   return enc_byte(8'ha0, v2, ST_RANGE2);
                        K_ABS:   return enc_word(8'hac, v2, ST_RANGE2);
                        K_ABSX:  return enc_word(8'hbc, v2, ST_RANGE2);
                        K_ZP:    return enc_byte(8'ha4, v2, ST_RANGE2);
                        K_ZPX:   return enc_byte(8'hb4, v2, ST_RANGE2);
                        default: return enc_err(ST_BAD_K2);
                    endcase
                end
                if (k2 == K_X) begin
                    case (k1)
                        K_S:     return enc_one(8'h9a);
                        K_ABS:   return enc_word(8'h8e, v1, ST_RANGE1);
                        K_ZP:    return enc_byte(8'h86, v1, ST_RANGE1);
                        K_ZPY:   return enc_byte(8'h96, v1, ST_RANGE1);
                        default: return enc_err(ST_BAD_K2);
                    endcase
                end
                if (k2 == K_Y) begin
                    case (k1)
                        K_ABS:   return enc_word(8'h8c, v1, ST_RANGE1);
                        K_ZP:    return enc_byte(8'h84, v1, ST_RANGE1);
                        K_ZPX:   return enc_byte(8'h94, v1, ST_RANGE1);
                        default: return enc_err(ST_BAD_K2);
                    endcase
                end
                if (k2 == K_IMM) begin
                    // store zero: the value is checked before the addressing kind
                    if (v2 != 0) return enc_err(ST_RANGE2);
                    case (k1)
                        K_ABS:   return enc_word(8'h9c, v1, ST_RANGE1);
                        K_ABSX:  return enc_word(8'h9e, v1, ST_RANGE1);
                        K_ZP:    return enc_byte(8'h64, v1, ST_RANGE1);
                        K_ZPX:   return enc_byte(8'h74, v1, ST_RANGE1);
                        default: return enc_err(ST_BAD_K2);
                    endcase
                end
                return enc_err(ST_BAD_K1);
            end
            OP_PULL: begin
                if (k2 != K_NONE) return enc_err(ST_BAD_K2);
                case (k1)
                    K_A:     return enc_one(8'h68);
                    K_X:     return enc_one(8'hfa);
                    K_Y:     return enc_one(8'h7a);
                    K_P:     return enc_one(8'h28);
                    default: return enc_err(ST_BAD_K1);
                endcase
            end
            OP_PUSH: begin
                if (k2 != K_NONE) return enc_err(ST_BAD_K2);
                case (k1)
                    K_A:     return enc_one(8'h48);
                    K_X:     return enc_one(8'hda);
                    K_Y:     return enc_one(8'h5a);
                    K_P:     return enc_one(8'h08);
                    default: return enc_err(ST_BAD_K1);
                endcase
            end
            OP_SET: begin
                if (k2 != K_NONE) return enc_err(ST_BAD_K2);
                case (k1)
                    K_CF:    return enc_one(8'h38);
                    K_IF:    return enc_one(8'h78);
                    K_DF:    return enc_one(8'hf8);
                    default: return enc_err(ST_BAD_K1);
                endcase
            end
            OP_CLR: begin
                if (k2 != K_NONE) return enc_err(ST_BAD_K2);
                case (k1)
                    K_CF:    return enc_one(8'h18);
                    K_IF:    return enc_one(8'h58);
                    K_VF:    return enc_one(8'hb8);
                    K_DF:    return enc_one(8'hd8);
                    default: return enc_err(ST_BAD_K1);
                endcase
            end
            OP_ADDC, OP_SUBC, OP_AND, OP_OR, OP_XOR: return enc_acc(op, k1, v1, k2, v2);
            OP_INC, OP_DEC, OP_ROR, OP_ROL, OP_ASL, OP_LSR: begin
                if (k2 != K_NONE) return enc_err(ST_BAD_K2);
                case (op)
                    OP_INC: begin
                        if (k1 == K_A) return enc_one(8'h1a);
                        if (k1 == K_X) return enc_one(8'he8);
                        if (k1 == K_Y) return enc_one(8'hc8);
                        b = 8'he0;
                    end
                    OP_DEC: begin
                        if (k1 == K_A) return enc_one(8'h3a);
                        if (k1 == K_X) return enc_one(8'hca);
                        if (k1 == K_Y) return enc_one(8'h88);
                        b = 8'hc0;
                    end
                    OP_ROR:  b = 8'h60;
                    OP_ROL:  b = 8'h20;
                    OP_ASL:  b = 8'h00;
                    default: b = 8'h40;
                endcase
                case (k1)
                    K_A:     return enc_one(b + 8'h0a);
                    K_ABS:   return enc_word(b + 8'h0e, v1, ST_RANGE1);
                    K_ABSX:  return enc_word(b + 8'h1e, v1, ST_RANGE1);
                    K_ZP:    return enc_byte(b + 8'h06, v1, ST_RANGE1);
                    K_ZPX:   return enc_byte(b + 8'h16, v1, ST_RANGE1);
                    default: return enc_err(ST_BAD_K1);
                endcase
            end
            OP_CMP: begin
                if (k1 == K_X || k1 == K_Y) begin
                    b = (k1 == K_X) ? 8'he0 : 8'hc0;
                    case (k2)
                        K_IMM:   return enc_byte(b, v2, ST_RANGE2);
                        K_ABS:   return enc_word(b + 8'h0c, v2, ST_RANGE2);
                        K_ZP:    return enc_byte(b + 8'h04, v2, ST_RANGE2);
                        default: return enc_err(ST_BAD_K2);
                    endcase
                end
                return enc_acc(op, k1, v1, k2, v2);
            end
            OP_BIT: begin
                if (k2 != K_NONE) return enc_err(ST_BAD_K2);
                case (k1)
                    K_ABS:   return enc_word(8'h2c, v1, ST_RANGE1);
                    K_ABSX:  return enc_word(8'h3c, v1, ST_RANGE1);
                    K_IMM:   return enc_byte(8'h89, v1, ST_RANGE1);
                    K_ZP:    return enc_byte(8'h24, v1, ST_RANGE1);
                    K_ZPX:   return enc_byte(8'h34, v1, ST_RANGE1);
                    default: return enc_err(ST_BAD_K1);
                endcase
            end
            OP_TRB, OP_TSB: begin
                if (k2 != K_NONE) return enc_err(ST_BAD_K2);
                case (k1)
                    K_ABS:   return enc_word((op == OP_TRB) ? 8'h1c : 8'h0c, v1, ST_RANGE1);
                    K_ZP:    return enc_byte((op == OP_TRB) ? 8'h14 : 8'h04, v1, ST_RANGE1);
                    default: return enc_err(ST_BAD_K1);
                endcase
            end
            OP_NOP: begin
                if (k1 != K_NONE) return enc_err(ST_BAD_K1);
                if (k2 != K_NONE) return enc_err(ST_BAD_K2);
                return enc_one(8'hea);
            end
            OP_JMP: begin
                if (k2 != K_NONE) return enc_err(ST_BAD_K2);
                case (k1)
                    K_IMM:   return enc_word(8'h4c, v1, ST_RANGE1);
                    K_ABS:   return enc_word(8'h6c, v1, ST_RANGE1);
                    K_ABSX:  return enc_word(8'h7c, v1, ST_RANGE1);
                    default: return enc_err(ST_BAD_K1);
                endcase
            end
            OP_BR: begin
                // first value picks flag-set versus flag-clear, second is the target
                if (k2 != K_IMM) return enc_err(ST_BAD_K2);
                case (k1)
                    K_NF:    return enc_branch(cond_set ? 8'h30 : 8'h10, addr, v2);
                    K_VF:    return enc_branch(cond_set ? 8'h70 : 8'h50, addr, v2);
                    K_CF:    return enc_branch(cond_set ? 8'hb0 : 8'h90, addr, v2);
                    K_ZF:    return enc_branch(cond_set ? 8'hf0 : 8'hd0, addr, v2);
                    K_ALW:   return enc_branch(8'h80, addr, v2);
                    default: return enc_err(ST_BAD_K1);
                endcase
            end
            OP_CALL: begin
                if (k1 != K_IMM) return enc_err(ST_BAD_K1);
                if (k2 != K_NONE) return enc_err(ST_BAD_K2);
                return enc_word(8'h20, v1, ST_RANGE1);
            end
            OP_RET, OP_RETI, OP_STOP, OP_WAIT: begin
                if (k1 != K_NONE || k2 != K_NONE) return enc_err(ST_BAD_K1);
                case (op)
                    OP_RET:  return enc_one(8'h60);
                    OP_RETI: return enc_one(8'h40);
                    OP_STOP: return enc_one(8'hdb);
                    default: return enc_one(8'hcb);
                endcase
            end
            OP_BRK: begin
                // break is the zero opcode plus a padding byte
                if (k1 != K_NONE || k2 != K_NONE) return enc_err(ST_BAD_K1);
                return enc_byte(8'h00, longint'(BRK_PAD), ST_OK);
            end
            default: return enc_err(ST_BAD_OP);
        endcase
    endfunction

    class encode_scoreboard;
        ibe_out_t expected_results[$];
        int       mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        function void note_request(ibe_in_t req);
            expected_results.push_back(predict_encoding(req));
        endfunction

        function void check_result(ibe_out_t got);
            ibe_out_t want;
            if (expected_results.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result: status=%0d count=%0d bytes=%02h %02h %02h",
                             got.status, got.byte_count, got.first_byte, got.second_byte,
                             got.third_byte);
                mismatch_count++;
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status || got.byte_count !== want.byte_count ||
                got.first_byte !== want.first_byte || got.second_byte !== want.second_byte ||
                got.third_byte !== want.third_byte) begin
                if (mismatch_count < 10)
                    $display({"mismatch: expected status=%0d count=%0d bytes=%02h %02h %02h,",
                              " got status=%0d count=%0d bytes=%02h %02h %02h"},
                             want.status, want.byte_count, want.first_byte,
                             want.second_byte, want.third_byte,
                             got.status, got.byte_count, got.first_byte,
                             got.second_byte, got.third_byte);
                mismatch_count++;
            end
        endfunction
    endclass

endpackage

/* tb/tb_instruction_byte_encoder_unit.sv */
// top-level testbench for instruction_byte_encoder_unit: directed and random requests
// with random idling on both channels, results checked in order by the scoreboard
// depends on ibe_pkg and ibe_encode_tb_pkg
module tb_instruction_byte_encoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ibe_pkg::*;
    import ibe_encode_tb_pkg::*;

    localparam logic [4:0] OP_BAD_LO = 5'd29;
    localparam logic [4:0] OP_BAD_HI = 5'd31;
    localparam logic [4:0] K_BAD     = 5'd31;
    localparam int         RANDOM_REQUESTS = 650;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    ibe_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    ibe_out_t m_data;

    encode_scoreboard sb = new();

    int calm_left = 0;
    int gap;

    instruction_byte_encoder_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // both handshakes seen at the same edge: request noted before the result is checked
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_request(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    // mostly short pauses, a few long ones
    function automatic int idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic ibe_in_t mk_req(logic [31:0] addr, logic [4:0] op, logic [4:0] k1,
                                       logic [31:0] v1, logic [4:0] k2, logic [31:0] v2);
        ibe_in_t q;
        q.instr_addr   = addr;
        q.op_code      = op;
        q.first_kind   = k1;
        q.first_value  = v1;
        q.second_kind  = k2;
        q.second_value = v2;
        return q;
    endfunction

    // operand values: mostly in range, some at the range edges, some anything
    function automatic logic [31:0] random_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return $urandom_range(0, 255);
        if (r < 78) return $urandom_range(0, 65535);
        if (r < 90) begin
            case ($urandom_range(0, 4))
                0:       return 32'd256;
                1:       return 32'h0001_0000;
                2:       return 32'hffff_ffff;
                3:       return 32'h8000_0000;
                default: return 32'h7fff_ffff;
            endcase
        end
        return $urandom();
    endfunction

    function automatic ibe_in_t random_request();
        ibe_in_t     q;
        int unsigned r;
        int          off;
        q.instr_addr   = $urandom();
        q.first_value  = random_value();
        q.second_value = random_value();
        q.op_code      = 5'($urandom_range(OP_MOV, OP_WAIT));
        q.second_kind  = K_NONE;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            // pure noise
            q.op_code     = 5'($urandom_range(0, 31));
            q.first_kind  = 5'($urandom_range(0, 31));
            q.second_kind = 5'($urandom_range(0, 31));
            q.first_value = $urandom();
            return q;
        end
        case (q.op_code)
            OP_MOV: begin
                q.first_kind  = 5'($urandom_range(K_A, K_IZPY));
                q.second_kind = 5'($urandom_range(K_A, K_IZPY));
                if (q.second_kind == K_IMM && $urandom_range(0, 1) == 1) q.second_value = '0;
            end
            OP_PULL, OP_PUSH: q.first_kind = 5'($urandom_range(K_A, K_P));
            OP_SET, OP_CLR:   q.first_kind = 5'($urandom_range(K_NF, K_DF));
            OP_ADDC, OP_SUBC, OP_AND, OP_OR, OP_XOR: begin
                q.first_kind  = K_A;
                q.second_kind = 5'($urandom_range(K_IMM, K_IZPY));
            end
            OP_CMP: begin
                q.first_kind  = 5'($urandom_range(K_A, K_Y));
                q.second_kind = 5'($urandom_range(K_IMM, K_IZPY));
            end
            OP_INC, OP_DEC, OP_ROR, OP_ROL, OP_ASL, OP_LSR:
                q.first_kind = 5'($urandom_range(K_A, K_ZPX));
            OP_BIT, OP_TRB, OP_TSB, OP_JMP: q.first_kind = 5'($urandom_range(K_IMM, K_ZP));
            OP_BR: begin
                q.first_kind  = 5'($urandom_range(K_NF, K_ALW));
                q.second_kind = K_IMM;
                q.first_value = ($urandom_range(0, 1) == 1) ? 32'd0 : $urandom();
                if ($urandom_range(0, 19) == 0) begin
                    q.second_value = $urandom();
                end else begin
                    q.instr_addr = $urandom_range(0, 65535);
                    if ($urandom_range(0, 9) == 0)
                        q.instr_addr = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 130)
                                                                   : $urandom_range(65400, 65535);
                    off = int'($urandom_range(0, 280)) - 140;
                    q.second_value = q.instr_addr + 2 + off;
                end
            end
            OP_CALL: q.first_kind = K_IMM;
            default: q.first_kind = K_NONE;
        endcase
        // broken request: one operand kind scrambled
        if (r < 22) begin
            if ($urandom_range(0, 1) == 1) q.first_kind = 5'($urandom_range(0, 31));
            else q.second_kind = 5'($urandom_range(0, 31));
        end
        return q;
    endfunction

    // valid stays high across back-to-back requests
    task automatic send_request(input ibe_in_t req, input int pause);
        if (pause > 0) begin
            s_valid <= 1'b0;
            repeat (pause) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // result side: ready bursts of random length, a few very long ones
    initial begin
        int busy;
        int stall;
        @(posedge aclk);
        forever begin
            busy = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 30);
            repeat (busy) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
            stall = idle_gap();
            repeat (stall) begin
                m_ready <= 1'b0;
                @(posedge aclk);
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // loads and stores: byte and word edges, store to immediate, store zero
        send_request(mk_req(32'h0, OP_MOV, K_A, 32'h0, K_IMM, 32'd0), idle_gap());
        send_request(mk_req(32'hffff_ffff, OP_MOV, K_A, 32'h7fff_ffff, K_IMM, 32'd255),
                     idle_gap());
        send_request(mk_req(32'h8000_0000, OP_MOV, K_A, 32'h0, K_ABS, 32'd65536), idle_gap());
        send_request(mk_req(32'h0, OP_MOV, K_ABS, 32'd65535, K_A, 32'hffff_ffff), idle_gap());
        send_request(mk_req(32'h0, OP_MOV, K_IMM, 32'd5, K_A, 32'd0), idle_gap());
        send_request(mk_req(32'h0, OP_MOV, K_ZP, 32'd0, K_IMM, 32'd0), idle_gap());
        send_request(mk_req(32'h0, OP_MOV, K_IZP, 32'd0, K_IMM, 32'd7), idle_gap());
        send_request(mk_req(32'h0, OP_MOV, K_X, 32'd0, K_S, 32'd0), idle_gap());
        // stack, flags and bad kind codes
        send_request(mk_req(32'h0, OP_PULL, K_P, 32'd0, K_BAD, 32'd0), idle_gap());
        send_request(mk_req(32'h0, OP_PUSH, K_BAD, 32'd0, K_NONE, 32'd0), idle_gap());
        send_request(mk_req(32'h0, OP_SET, K_CF, 32'd0, K_NONE, 32'd0), idle_gap());
        send_request(mk_req(32'h0, OP_CLR, K_VF, 32'd0, K_NONE, 32'd0), idle_gap());
        // accumulator group
        send_request(mk_req(32'h0, OP_ADDC, K_A, 32'd0, K_IZPY, 32'h7fff_ffff), idle_gap());
        send_request(mk_req(32'h0, OP_SUBC, K_A, 32'd0, K_ABS, 32'd65535), idle_gap());
        send_request(mk_req(32'h0, OP_AND, K_A, 32'd0, K_IMM, 32'd0), idle_gap());
        send_request(mk_req(32'h0, OP_OR, K_A, 32'd0, K_ZPX, 32'd255), idle_gap());
        send_request(mk_req(32'h0, OP_XOR, K_A, 32'd0, K_IZPX, 32'h8000_0000), idle_gap());
        // read-modify-write group, then compare, bit test, nop and jump
        send_request(mk_req(32'h0, OP_INC, K_X, 32'd0, K_NONE, 32'd0), idle_gap());
        send_request(mk_req(32'h0, OP_DEC, K_A, 32'd0, K_NONE, 32'd0), idle_gap());
        send_request(mk_req(32'h0, OP_ROR, K_ZP, 32'd256, K_NONE, 32'd0), idle_gap());
        send_request(mk_req(32'h0, OP_ROL, K_ABS, 32'd0, K_NONE, 32'd0), idle_gap());
        send_request(mk_req(32'h0, OP_ASL, K_A, 32'd0, K_NONE, 32'd0), idle_gap());
        send_request(mk_req(32'h0, OP_LSR, K_ABSX, 32'd65535, K_NONE, 32'd0), idle_gap());
        send_request(mk_req(32'h0, OP_CMP, K_Y, 32'd0, K_IMM, 32'd255), idle_gap());
        send_request(mk_req(32'h0, OP_BIT, K_IMM, 32'd0, K_NONE, 32'd0), idle_gap());
        send_request(mk_req(32'h0, OP_TRB, K_ABS, 32'd65536, K_NONE, 32'd0), idle_gap());
        send_request(mk_req(32'h0, OP_TSB, K_ZP, 32'd255, K_NONE, 32'd0), idle_gap());
        send_request(mk_req(32'h0, OP_NOP, K_NONE, 32'd0, K_NONE, 32'd0), idle_gap());
        send_request(mk_req(32'h0, OP_JMP, K_IMM, 32'd65535, K_NONE, 32'd0), idle_gap());
        // branches: farthest forward and back, one too far, address out of range
        send_request(mk_req(32'd0, OP_BR, K_NF, 32'd1, K_IMM, 32'd129), idle_gap());
        send_request(mk_req(32'd65535, OP_BR, K_ALW, 32'd0, K_IMM, 32'd65409), idle_gap());
        send_request(mk_req(32'd100, OP_BR, K_CF, 32'd0, K_IMM, 32'd230), idle_gap());
        send_request(mk_req(32'hffff_ffff, OP_BR, K_ZF, 32'd0, K_IMM, 32'd0), idle_gap());
        // control flow, break padding and invalid operations
        send_request(mk_req(32'h0, OP_CALL, K_IMM, 32'h1234, K_NONE, 32'd0), idle_gap());
        send_request(mk_req(32'h0, OP_RET, K_A, 32'd0, K_NONE, 32'd0), idle_gap());
        send_request(mk_req(32'h0, OP_RETI, K_NONE, 32'd0, K_NONE, 32'd0), idle_gap());
        send_request(mk_req(32'h0, OP_BRK, K_NONE, 32'd0, K_NONE, 32'd0), idle_gap());
        send_request(mk_req(32'h0, OP_STOP, K_NONE, 32'd0, K_NONE, 32'd0), idle_gap());
        send_request(mk_req(32'h0, OP_WAIT, K_NONE, 32'd0, K_NONE, 32'd0), idle_gap());
        send_request(mk_req(32'h0, OP_BAD_LO, K_NONE, 32'd0, K_NONE, 32'd0), idle_gap());
        send_request(mk_req(32'h0, OP_BAD_HI, K_BAD, 32'hffff_ffff, K_BAD, 32'hffff_ffff),
                     idle_gap());

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if (calm_left > 0) begin
                calm_left--;
                gap = 0;
            end else begin
                gap = idle_gap();
                if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 40);
            end
            send_request(random_request(), gap);
        end
        s_valid <= 1'b0;

        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.mismatch_count == 0 && sb.expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
